FILE: src/lpi_pkg.sv
// Shared constants for the line point interpolator.
// No dependencies; imported by lpi_div_pipe and line_point_interpolator.
package lpi_pkg;

  // Default coordinate width in bits; the block supports 4 to 16.
  localparam int unsigned COORD_BITS_DEF = 12;

endpackage

FILE: src/lpi_div_pipe.sv
// Pipelined restoring divider for the two axes, one quotient bit per stage.
// Depends on lpi_pkg; instantiated by line_point_interpolator.
module lpi_div_pipe
  import lpi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned SIDE_W     = 2 * COORD_BITS_DEF + 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2*COORD_BITS-1:0]   m_i [2],
  input  logic [COORD_BITS-1:0]     n_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COORD_BITS-1:0]     q_o [2],
  output logic [COORD_BITS-1:0]     r_o [2],
  output logic [COORD_BITS-1:0]     n_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned C = COORD_BITS;

  logic [C-1:0]      rem_q  [C][2];
  logic [C-1:0]      low_q  [C][2];
  logic [C-1:0]      quo_q  [C][2];
  logic [C-1:0]      n_q    [C];
  logic [SIDE_W-1:0] side_q [C];
  logic [C-1:0]      v_q;
  logic [C:0]        rdy;

  assign rdy[C] = out_ready_i;

  for (genvar i = 0; i < C; i++) begin : g_stage
    logic [C-1:0]      rem_s [2];
    logic [C-1:0]      low_s [2];
    logic [C-1:0]      quo_s [2];
    logic [C-1:0]      rem_d [2];
    logic [C-1:0]      low_d [2];
    logic [C-1:0]      quo_d [2];
    logic [C-1:0]      n_s;
    logic [SIDE_W-1:0] side_s;
    logic              v_s;

    if (i == 0) begin : g_src
      // The quotient fits in C bits, so the upper half of the dividend is
      // already below the divisor and seeds the partial remainder.
      for (genvar a = 0; a < 2; a++) begin : g_axis
        assign rem_s[a] = m_i[a][2*C-1:C];
        assign low_s[a] = m_i[a][C-1:0];
        assign quo_s[a] = '0;
      end
      assign n_s    = n_i;
      assign side_s = side_i;
      assign v_s    = in_valid_i;
    end else begin : g_src
      assign rem_s  = rem_q[i-1];
      assign low_s  = low_q[i-1];
      assign quo_s  = quo_q[i-1];
      assign n_s    = n_q[i-1];
      assign side_s = side_q[i-1];
      assign v_s    = v_q[i-1];
    end

    always_comb begin
      logic [C:0] r2;
      logic [C:0] diff;
      logic       ge;
      for (int a = 0; a < 2; a++) begin
        r2       = {rem_s[a], low_s[a][C-1]};
        diff     = r2 - {1'b0, n_s};
        ge       = (r2 >= {1'b0, n_s});
        rem_d[a] = ge ? diff[C-1:0] : r2[C-1:0];
        low_d[a] = {low_s[a][C-2:0], 1'b0};
        quo_d[a] = {quo_s[a][C-2:0], ge};
      end
    end

    assign rdy[i] = !v_q[i] || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && v_s) begin
        rem_q[i]  <= rem_d;
        low_q[i]  <= low_d;
        quo_q[i]  <= quo_d;
        n_q[i]    <= n_s;
        side_q[i] <= side_s;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[C-1];
  assign q_o         = quo_q[C-1];
  assign r_o         = rem_q[C-1];
  assign n_o         = n_q[C-1];
  assign side_o      = side_q[C-1];

endmodule

FILE: src/line_point_interpolator.sv
// Line point interpolator: grid point at a given step of a line segment.
//
// Input stream (s_axis): one transfer carries both endpoints and a step
// index. The output stream (m_axis) returns one transfer per input: the
// point in tdata, tlast high when the step equals the step count N, and
// tuser high when the step was beyond N and clamped to the end point.
// N is the larger of |end_x - start_x| and |end_y - start_y|; each
// coordinate is start + d*step/N rounded to nearest, ties away from zero.
// A zero-length segment returns the start point.
//
// The pipeline has one stage for the deltas and clamp, one for the products,
// one per quotient bit in the divider pipeline, and two for rounding. A new
// transfer is taken every cycle unless a stalled receiver holds the pipeline.
// Each stage holds its item while the next one is full, and empty
// stages keep filling, so a stalled receiver loses or repeats nothing and
// the input keeps accepting until the pipeline is full.
// Reset clears all valid bits; the pipeline comes up empty.
module line_point_interpolator
  import lpi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // start_x, start_y, end_x, end_y, step_index (lowest bits first)
  input  logic [((5*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // point_x, point_y (lowest bits first)
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  output logic                                   m_axis_tlast,
  // step_saturated
  output logic                                   m_axis_tuser
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned W      = COORD_BITS + 2;
  localparam int unsigned SIDE_W = 2 * COORD_BITS + 5;
  localparam int unsigned OUT_W  = ((2*COORD_BITS+7)/8)*8;

  // ---------------- Stage 1: deltas, step count, clamp ----------------
  logic [C-1:0] in_sx, in_sy, in_ex, in_ey, in_step;
  logic [C:0]   dx, dy;
  logic [C-1:0] adx, ady, n_c, k_c;
  logic         in_sat, in_last;

  assign in_sx   = s_axis_tdata[C-1:0];
  assign in_sy   = s_axis_tdata[2*C-1:C];
  assign in_ex   = s_axis_tdata[3*C-1:2*C];
  assign in_ey   = s_axis_tdata[4*C-1:3*C];
  assign in_step = s_axis_tdata[5*C-1:4*C];

  always_comb begin
    logic [C:0] ndx;
    logic [C:0] ndy;
    dx      = {in_ex[C-1], in_ex} - {in_sx[C-1], in_sx};
    dy      = {in_ey[C-1], in_ey} - {in_sy[C-1], in_sy};
    ndx     = -dx;
    ndy     = -dy;
    adx     = dx[C] ? ndx[C-1:0] : dx[C-1:0];
    ady     = dy[C] ? ndy[C-1:0] : dy[C-1:0];
    n_c     = (adx > ady) ? adx : ady;
    in_sat  = (in_step > n_c);
    in_last = (in_step == n_c);
    k_c     = in_sat ? n_c : in_step;
  end

  logic         v1_q, v2_q, v3_q, v4_q;
  logic         rdy1, rdy2, rdy3, rdy4;
  logic         div_in_ready, div_out_valid;

  logic [C-1:0] s1_sx_q, s1_sy_q, s1_adx_q, s1_ady_q, s1_n_q, s1_k_q;
  logic         s1_negx_q, s1_negy_q, s1_sat_q, s1_last_q;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || div_in_ready;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      s1_sx_q   <= in_sx;
      s1_sy_q   <= in_sy;
      s1_adx_q  <= adx;
      s1_ady_q  <= ady;
      s1_negx_q <= dx[C];
      s1_negy_q <= dy[C];
      s1_n_q    <= n_c;
      s1_k_q    <= k_c;
      s1_sat_q  <= in_sat;
      s1_last_q <= in_last;
    end
  end

  // ---------------- Stage 2: |d| * k per axis ----------------
  logic [2*C-1:0]    s2_m_q [2];
  logic [C-1:0]      s2_n_q;
  logic [SIDE_W-1:0] s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_m_q[0] <= s1_adx_q * s1_k_q;
      s2_m_q[1] <= s1_ady_q * s1_k_q;
      s2_n_q    <= s1_n_q;
      s2_side_q <= {s1_sat_q, s1_last_q, (s1_n_q != '0), s1_negy_q, s1_negx_q,
                    s1_sy_q, s1_sx_q};
    end
  end

  // ---------------- Divider pipeline ----------------
  logic [C-1:0]      dv_q [2];
  logic [C-1:0]      dv_r [2];
  logic [C-1:0]      dv_n;
  logic [SIDE_W-1:0] dv_side;

  lpi_div_pipe #(
    .COORD_BITS (COORD_BITS),
    .SIDE_W     (SIDE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_ready_o  (div_in_ready),
    .m_i         (s2_m_q),
    .n_i         (s2_n_q),
    .side_i      (s2_side_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy3),
    .q_o         (dv_q),
    .r_o         (dv_r),
    .n_o         (dv_n),
    .side_o      (dv_side)
  );

  // ---------------- Stage 3: integer part and fraction numerator ----------------
  // For a negative delta with a nonzero remainder the value is rewritten as
  // (s - Q - 1) + (N - R)/N, so both signs round with the same rule.
  logic [C-1:0] dv_s [2];
  logic         dv_neg [2];
  logic [W-1:0] base_d [2];
  logic [C-1:0] frac_d [2];

  assign dv_s[0]   = dv_side[C-1:0];
  assign dv_s[1]   = dv_side[2*C-1:C];
  assign dv_neg[0] = dv_side[2*C];
  assign dv_neg[1] = dv_side[2*C+1];

  always_comb begin
    logic [W-1:0] sw;
    logic [W-1:0] qw;
    for (int a = 0; a < 2; a++) begin
      sw = {{2{dv_s[a][C-1]}}, dv_s[a]};
      qw = {2'b00, dv_q[a]};
      if (!dv_neg[a]) begin
        base_d[a] = sw + qw;
        frac_d[a] = dv_r[a];
      end else if (dv_r[a] == '0) begin
        base_d[a] = sw - qw;
        frac_d[a] = '0;
      end else begin
        base_d[a] = sw - qw - W'(1);
        frac_d[a] = dv_n - dv_r[a];
      end
    end
  end

  logic [W-1:0] s3_base_q [2];
  logic [C-1:0] s3_frac_q [2];
  logic [C-1:0] s3_s_q    [2];
  logic [C-1:0] s3_n_q;
  logic         s3_nz_q, s3_last_q, s3_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && div_out_valid) begin
      s3_base_q <= base_d;
      s3_frac_q <= frac_d;
      s3_s_q    <= dv_s;
      s3_n_q    <= dv_n;
      s3_nz_q   <= dv_side[2*C+2];
      s3_last_q <= dv_side[2*C+3];
      s3_sat_q  <= dv_side[2*C+4];
    end
  end

  // ---------------- Stage 4: round to nearest, ties away from zero ----------------
  logic [C-1:0] pt_d [2];

  always_comb begin
    logic [C:0]   twice;
    logic [C:0]   nn;
    logic         up;
    logic [W-1:0] res;
    nn = {1'b0, s3_n_q};
    for (int a = 0; a < 2; a++) begin
      twice = {s3_frac_q[a], 1'b0};
      up    = (twice > nn) || ((twice == nn) && !s3_base_q[a][W-1]);
      res   = s3_base_q[a] + {{(W-1){1'b0}}, up};
      pt_d[a] = s3_nz_q ? res[C-1:0] : s3_s_q[a];
    end
  end

  logic [C-1:0] s4_pt_q [2];
  logic         s4_last_q, s4_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      s4_pt_q   <= pt_d;
      s4_last_q <= s3_last_q;
      s4_sat_q  <= s3_sat_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = OUT_W'({s4_pt_q[1], s4_pt_q[0]});
  assign m_axis_tlast  = s4_last_q;
  assign m_axis_tuser  = s4_sat_q;

endmodule
